>>> rtl/core/ftm_pkg.sv
// Shared types and constants for the face terminal match unit.
package ftm_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  localparam int ID_W  = 20;
  localparam int POS_W = 16;
  localparam int RAD_W = 12;
  localparam int OFF_W = 12;
  localparam int MR_W  = 8;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  node_id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [RAD_W-1:0] node_radius;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] query_id;
    logic [ID_W-1:0] match_id;
    logic            matched;
  } result_t;

endpackage

>>> rtl/core/ftm_front.sv
// Front end: input decode and a two-entry item queue.
module ftm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ftm_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                      q_valid,
  input  logic                      q_pop,
  output ftm_pkg::item_t            q_item
);
  import ftm_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      din;
  logic       push;

  assign din.cmd         = in_tdata[1:0];
  assign din.node_id     = in_tdata[21:2];
  assign din.pos_x       = in_tdata[37:22];
  assign din.pos_y       = in_tdata[53:38];
  assign din.pos_z       = in_tdata[69:54];
  assign din.node_radius = in_tdata[81:70];

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overfull");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready) else $error("ready while full");

endmodule

>>> rtl/core/ftm_back.sv
// Back end: node table, candidate scan, scoring and result register.
module ftm_back #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  ftm_pkg::item_t       q_item,
  input  logic [ftm_pkg::OFF_W-1:0] off_x,
  input  logic [ftm_pkg::OFF_W-1:0] off_y,
  input  logic [ftm_pkg::OFF_W-1:0] off_z,
  input  logic [ftm_pkg::MR_W-1:0]  mrad,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ftm_pkg::result_t     res
);
  import ftm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_DIST = 3'd2,
                         S_SQ = 3'd3, S_CUBE = 3'd4, S_CMP = 3'd5, S_OUT = 3'd6;
  localparam int EW = ID_W + 3 * POS_W + RAD_W;

  logic [EW-1:0] tbl [DEPTH];
  logic [AW:0]   cnt_r;
  logic [AW:0]   idx_r;
  logic [2:0]    st_r;
  logic [EW-1:0] ent_r;
  item_t         qi_r;
  logic signed [17:0] cx_r, cy_r, cz_r;
  logic [31:0]   lim2_r;
  logic          d3_r;
  logic [24:0]   d2_r;
  logic [11:0]   rd_r;
  logic [49:0]   sq_r;
  logic [101:0]  sc_r;
  logic [101:0]  best_r;
  logic          found_r;
  logic [ID_W-1:0] bid_r;
  logic          rv_r;
  result_t       res_r;

  logic [ID_W-1:0]  e_id;
  logic [POS_W-1:0] e_x, e_y, e_z;
  logic [RAD_W-1:0] e_r;
  logic signed [18:0] dx, dy, dz;
  logic [15:0]   rlim;
  logic [49:0]   pp_hi, pp_lo;
  logic [101:0]  cube;
  logic          qi_cmd_query;

  assign {e_id, e_x, e_y, e_z, e_r} = ent_r;
  assign dx   = $signed({3'b0, e_x}) - cx_r;
  assign dy   = $signed({3'b0, e_y}) - cy_r;
  assign dz   = $signed({3'b0, e_z}) - cz_r;
  assign rlim = {4'b0, mrad, 4'b0};
  // d2 < 2^25 for any candidate; cube built from two 25x25 partial products
  assign pp_hi = sq_r[49:25] * d2_r;
  assign pp_lo = sq_r[24:0] * d2_r;
  assign cube  = {27'b0, pp_hi, 25'b0} + {52'b0, pp_lo};

  assign qi_cmd_query = (q_item.cmd == CMD_QUERY);
  assign q_pop     = q_valid && (st_r == S_IDLE) && !(qi_cmd_query && rv_r);
  assign res_valid = rv_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_item.cmd == CMD_LOAD && cnt_r < (AW+1)'(DEPTH))
      tbl[cnt_r[AW-1:0]] <= {q_item.node_id, q_item.pos_x, q_item.pos_y,
                             q_item.pos_z, q_item.node_radius};
    ent_r <= tbl[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; rv_r <= 1'b0; idx_r <= '0; found_r <= 1'b0;
    end else begin
      if (rv_r && res_ready && st_r != S_OUT) rv_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_pop) begin
          unique case (q_item.cmd)
            CMD_LOAD:  if (cnt_r < (AW+1)'(DEPTH)) cnt_r <= cnt_r + 1'b1;
            CMD_CLEAR: cnt_r <= '0;
            CMD_QUERY: begin
              qi_r    <= q_item;
              cx_r    <= $signed({2'b0, q_item.pos_x}) - $signed({2'b0, off_x, 4'b0});
              cy_r    <= $signed({2'b0, q_item.pos_y}) - $signed({2'b0, off_y, 4'b0});
              cz_r    <= $signed({2'b0, q_item.pos_z}) - $signed({2'b0, off_z, 4'b0});
              lim2_r  <= rlim * rlim;
              idx_r   <= '0;
              found_r <= 1'b0;
              st_r    <= (cnt_r == '0) ? S_OUT : S_RD;
            end
            default: ;
          endcase
        end
        S_RD: st_r <= S_DIST;
        S_DIST: begin
          d2_r <= 25'(34'(dx * dx) + 34'(dy * dy));
          // 36 bits hold the full sum of three squares without wrap
          d3_r <= (36'(dx * dx) + 36'(dy * dy) + 36'(dz * dz)) > {4'b0, lim2_r};
          rd_r <= (qi_r.node_radius >= e_r) ? qi_r.node_radius - e_r
                                              : e_r - qi_r.node_radius;
          st_r <= S_SQ;
        end
        S_SQ: begin
          sq_r <= d2_r * d2_r;
          st_r <= S_CUBE;
        end
        S_CUBE: begin
          sc_r <= cube + {62'b0, 24'(rd_r * rd_r), 16'b0};
          st_r <= S_CMP;
        end
        S_CMP: begin
          if (!d3_r && (!found_r || sc_r < best_r)) begin
            found_r <= 1'b1; best_r <= sc_r; bid_r <= e_id;
          end
          if (idx_r + 1'b1 >= cnt_r) st_r <= S_OUT;
          else begin idx_r <= idx_r + 1'b1; st_r <= S_RD; end
        end
        S_OUT: if (!rv_r || res_ready) begin
          rv_r  <= 1'b1;
          res_r <= '{query_id: qi_r.node_id, match_id: found_r ? bid_r : '0,
                     matched: found_r};
          st_r  <= S_IDLE;
        end else begin
          rv_r  <= 1'b1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("count over depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CMP) |-> idx_r < cnt_r) else $error("scan past count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !res_ready) |=> $stable(res_r)) else $error("result changed");

endmodule

>>> rtl/core/face_terminal_match_unit.sv
// Top level of the face terminal match unit.
// Load, clear: taken in the back end's idle state. Query: scans the N stored
// nodes in turn via the single-read table port: S_RD, S_DIST, S_SQ, S_CUBE, S_CMP.
// Result registered; loads and clears still taken while it waits, a query is held.
// Input queue two deep.
// Reset (rst_n, sync low): table empty, offsets 0, match radius 16.
module face_terminal_match_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd, node_id, pos_x, pos_y, pos_z, node_radius, zero fill
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // query_id, match_id, matched, zero fill
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  import ftm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [OFF_W-1:0] offx_r, offy_r, offz_r;
  logic [MR_W-1:0]  mrad_r;
  logic    qv, qp;
  item_t   qi;
  result_t rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r <= '0; offy_r <= '0; offz_r <= '0; mrad_r <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: offx_r <= cfg_wdata;
        REG_OFFSET_Y: offy_r <= cfg_wdata;
        REG_OFFSET_Z: offz_r <= cfg_wdata;
        REG_RADIUS:   mrad_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ftm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid(qv), .q_pop(qp), .q_item(qi)
  );

  ftm_back #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_pop(qp), .q_item(qi),
    .off_x(offx_r), .off_y(offy_r), .off_z(offz_r), .mrad(mrad_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(rs)
  );

  assign out_tdata = {7'b0, rs.matched, rs.match_id, rs.query_id};

endmodule

>>> test/testbench.sv
// Self-checking testbench for the face terminal match unit.
`timescale 1ns / 100ps

module testbench;
  import ftm_pkg::*;

  localparam int DEPTH = 64;

  // clock, reset and DUT ports
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [87:0]  in_tdata;   // cmd, node_id, pos_x, pos_y, pos_z, node_radius, zero fill
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;  // query_id, match_id, matched, zero fill
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [11:0]  cfg_wdata;

  face_terminal_match_unit #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [1:0]  cmd;
    logic [19:0] id;
    logic [15:0] px, py, pz;
    logic [11:0] r;
  } node_t;

  typedef struct {
    logic [19:0] query_id;
    logic [19:0] match_id;
    logic        matched;
  } match_t;

  // predictor state: node table and register copies
  node_t       node_table[DEPTH];
  int          node_count;
  logic [11:0] shift_x, shift_y, shift_z;
  logic [7:0]  sphere_r;

  node_t  pending_items[$];
  match_t expected_matches[$];
  int     error_count;
  int     stall_hold;      // long receiver hold-off, set by stimulus
  logic   send_gate;       // driver may offer items
  logic   sink_gate;       // monitor throttles results at random

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted item to the model; queue the result of a query.
  function automatic void predict_match(node_t it);
    longint cx, cy, cz, dx, dy, dz, rlim2, d3, rd;
    logic [127:0] d2, score, best;
    logic         found;
    logic [19:0]  best_id;
    match_t       m;
    case (it.cmd)
      CMD_LOAD: if (node_count < DEPTH) begin
        node_table[node_count] = it;
        node_count++;
      end
      CMD_CLEAR: node_count = 0;
      CMD_QUERY: begin
        cx = longint'(it.px) - longint'(shift_x) * 16;
        cy = longint'(it.py) - longint'(shift_y) * 16;
        cz = longint'(it.pz) - longint'(shift_z) * 16;
        rlim2 = (longint'(sphere_r) * 16) * (longint'(sphere_r) * 16);
        found = 1'b0;
        best_id = '0;
        best = '0;
        for (int i = 0; i < node_count; i++) begin
          dx = longint'(node_table[i].px) - cx;
          dy = longint'(node_table[i].py) - cy;
          dz = longint'(node_table[i].pz) - cz;
          d2 = 128'(dx * dx + dy * dy);
          d3 = dx * dx + dy * dy + dz * dz;
          if (d3 <= rlim2) begin
            rd = (it.r >= node_table[i].r) ? longint'(it.r - node_table[i].r)
                                            : longint'(node_table[i].r - it.r);
            score = d2 * d2 * d2 + (128'(rd * rd) << 16);
            // strict less: earliest candidate keeps a tie
            if (!found || score < best) begin
              found = 1'b1;
              best = score;
              best_id = node_table[i].id;
            end
          end
        end
        m.query_id = it.id;
        m.match_id = best_id;
        m.matched = found;
        expected_matches.push_back(m);
      end
      default: ;  // unused command: nothing
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [19:0] got,
                                 input logic [19:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Driver: gaps between items are mostly short, a few long.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      // current item (if any) consumed this edge
      if (in_tvalid) begin
        predict_match(pending_items.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (send_gate && pending_items.size() > 0) begin
        node_t nx;
        nx = pending_items[0];
        in_tvalid <= 1'b1;
        in_tdata <= {nx.r, nx.pz, nx.py, nx.px, nx.id, nx.cmd};
        case ($urandom_range(0, 9))
          0, 1, 2: send_gap <= $urandom_range(1, 3);
          3:       send_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : 0;
          default: send_gap <= 0;
        endcase
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[19:0], 20'd0);
        end else begin
          match_t w;
          w = expected_matches.pop_front();
          if (out_tdata[19:0] !== w.query_id)
            report_mismatch("query_id", out_tdata[19:0], w.query_id);
          if (out_tdata[39:20] !== w.match_id)
            report_mismatch("match_id", out_tdata[39:20], w.match_id);
          if (out_tdata[40] !== w.matched)
            report_mismatch("matched", 20'(out_tdata[40]), 20'(w.matched));
          if (out_tdata[47:41] !== '0)
            report_mismatch("fill", 20'(out_tdata[47:41]), 20'd0);
        end
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_tready <= 1'b0;
      end else if (!sink_gate) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 9) < 7) ||
                      ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog
  initial begin
    #40ms;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic node_t rand_node(logic [1:0] c);
    node_t n;
    n.cmd = c;
    n.id = 20'($urandom);
    n.px = 16'($urandom);
    n.py = 16'($urandom);
    n.pz = 16'($urandom);
    n.r = 12'($urandom);
    return n;
  endfunction

  // Node near a base point, so queries land inside the sphere.
  function automatic node_t near_node(logic [1:0] c, node_t b, int spread);
    node_t n;
    n = rand_node(c);
    n.px = b.px + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
    n.py = b.py + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
    n.pz = b.pz + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
    if ($urandom_range(0, 2) == 0) n.r = b.r + 12'($urandom_range(0, 4));
    return n;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_matches.size() > 0)
      @(posedge clk);
    // loads and clears still in the input queue may still run
    repeat (5 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_X: shift_x = val;
      REG_OFFSET_Y: shift_y = val;
      REG_OFFSET_Z: shift_z = val;
      default:      sphere_r = val[7:0];
    endcase
  endtask

  initial begin
    node_t n, b;
    int sent;
    error_count = 0;
    node_count = 0;
    shift_x = '0; shift_y = '0; shift_z = '0;
    sphere_r = 8'd16;
    stall_hold = 0;
    send_gate = 1'b1;
    sink_gate = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_OFFSET_X; cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty query, extremes, tie, full table, clear, unused cmd
    n = rand_node(CMD_QUERY); pending_items.push_back(n);
    n = '{CMD_LOAD, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF};
    pending_items.push_back(n);
    n = '{CMD_LOAD, 20'd0, 16'd0, 16'd0, 16'd0, 12'd0}; pending_items.push_back(n);
    n = '{CMD_LOAD, 20'd7, 16'd100, 16'd100, 16'd100, 12'd20}; pending_items.push_back(n);
    n = '{CMD_LOAD, 20'd8, 16'd100, 16'd100, 16'd100, 12'd20}; pending_items.push_back(n);
    n = '{CMD_QUERY, 20'hABCDE, 16'd100, 16'd100, 16'd100, 12'd20}; pending_items.push_back(n);
    n = '{CMD_QUERY, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF};
    pending_items.push_back(n);
    n = '{CMD_QUERY, 20'd1, 16'd0, 16'd0, 16'd256, 12'd0}; pending_items.push_back(n);
    n = '{CMD_QUERY, 20'd2, 16'd0, 16'd0, 16'd257, 12'd0}; pending_items.push_back(n);
    n = rand_node(2'd3); pending_items.push_back(n);
    n = rand_node(CMD_CLEAR); pending_items.push_back(n);
    n = '{CMD_QUERY, 20'd3, 16'd100, 16'd100, 16'd100, 12'd20}; pending_items.push_back(n);
    for (int i = 0; i < DEPTH + 2; i++) begin
      n = rand_node(CMD_LOAD); n.px = 16'(i * 4); n.py = 16'd50; n.pz = 16'd50;
      pending_items.push_back(n);
    end
    n = '{CMD_QUERY, 20'd4, 16'd0, 16'd50, 16'd50, 12'd9}; pending_items.push_back(n);
    wait_idle();

    // offset and radius extremes on a full table
    write_reg(REG_OFFSET_X, 12'hFFF);
    write_reg(REG_OFFSET_Y, 12'hFFF);
    write_reg(REG_OFFSET_Z, 12'hFFF);
    write_reg(REG_RADIUS, 12'd255);
    sink_gate = 1'b1;
    n = '{CMD_QUERY, 20'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd0}; pending_items.push_back(n);
    wait_idle();
    write_reg(REG_RADIUS, 12'd0);
    n = '{CMD_QUERY, 20'd6, 16'd0, 16'd50, 16'd50, 12'd0}; pending_items.push_back(n);
    wait_idle();

    // random phases with varied settings
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_OFFSET_X, (ph == 1) ? 12'hFFF : 12'($urandom_range(0, 300)));
      write_reg(REG_OFFSET_Y, 12'($urandom_range(0, 300)));
      write_reg(REG_OFFSET_Z, (ph == 2) ? 12'hFFF : 12'($urandom_range(0, 300)));
      write_reg(REG_RADIUS, (ph == 3) ? 12'd0 : (ph == 4) ? 12'd255
                                      : 12'($urandom_range(1, 40)));
      if (ph == 2) stall_hold = 600;  // long hold-off, input backs up
      for (int k = 0; k < 100; k++) begin
        logic [7:0] sel;
        sel = 8'($urandom_range(0, 99));
        if (k == 0 || sel < 3) begin
          b = rand_node(CMD_LOAD);
          b.px = 16'($urandom_range(0, 60000)); b.py = 16'($urandom_range(0, 60000));
          b.pz = 16'($urandom_range(0, 60000));
        end
        if (sel < 2) n = rand_node(CMD_CLEAR);
        else if (sel < 3) n = rand_node(2'd3);
        else if (sel < 8) n = rand_node(2'($urandom_range(0, 1)));
        else if (sel < 50) n = near_node(CMD_LOAD, b, 400);
        else begin
          n = near_node(CMD_QUERY, b, 300);
          n.px = n.px + {shift_x, 4'd0};
          n.py = n.py + {shift_y, 4'd0};
          n.pz = n.pz + {shift_z, 4'd0};
        end
        pending_items.push_back(n);
        sent++;
      end
      if (ph == 5) begin
        // sender pauses until the result stream has drained
        send_gate = 1'b0;
        while (expected_matches.size() > 0 || in_tvalid) @(posedge clk);
        send_gate = 1'b1;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
